@@ sv/aat_pkg.sv @@
// shared types and constants for the aabb affine transform block
// no dependencies; imported by every module of the block
package aat_pkg;

    localparam int Q_W     = 32;
    localparam int EXT_W   = 31;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int DIM     = 3;
    localparam int CP_W    = 2 * Q_W;
    localparam int EP_W    = Q_W + EXT_W;
    localparam int FRAC_W  = 16;
    localparam int CSUM_W  = CP_W + 2;
    localparam int ESUM_W  = EP_W + 2;

    localparam logic [Q_W-1:0]   Q_ONE     = 32'h0001_0000;
    localparam logic [Q_W-1:0]   CTR_MAX   = 32'h7fff_ffff;
    localparam logic [Q_W-1:0]   CTR_MIN   = 32'h8000_0000;
    localparam logic [EXT_W-1:0] EXT_MAX   = 31'h7fff_ffff;
    localparam int               ROUND_HALF = 32768;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] box_center_x;
        logic signed [Q_W-1:0] box_center_y;
        logic signed [Q_W-1:0] box_center_z;
        logic [EXT_W-1:0]      half_extent_x;
        logic [EXT_W-1:0]      half_extent_y;
        logic [EXT_W-1:0]      half_extent_z;
    } t_box_in;

    typedef struct packed {
        logic signed [Q_W-1:0] new_center_x;
        logic signed [Q_W-1:0] new_center_y;
        logic signed [Q_W-1:0] new_center_z;
        logic [EXT_W-1:0]      new_extent_x;
        logic [EXT_W-1:0]      new_extent_y;
        logic [EXT_W-1:0]      new_extent_z;
    } t_box_out;

    typedef struct packed {
        logic [DIM-1:0][DIM-1:0][Q_W-1:0] m;
        logic [DIM-1:0][DIM-1:0][Q_W-1:0] m_abs;
        logic [DIM-1:0][Q_W-1:0]          tr;
    } t_matrix;

    typedef struct packed {
        logic [DIM-1:0][DIM-1:0][CP_W-1:0] cp;
        logic [DIM-1:0][DIM-1:0][EP_W-1:0] ep;
    } t_prod;

    function automatic logic [Q_W-1:0] abs_q(input logic [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + Q_W'(1)) : v;
    endfunction

endpackage

@@ sv/aabb_affine_transform.sv @@
// top level: bounding box of an axis-aligned box after an affine transform
// depends on aat_pkg, aat_cfg_regs, aat_mul_stage, aat_sum_stage
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_box (t_box_in)
//   result    out        o_valid / i_ready      o_box (t_box_out)
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// one item per cycle sustained while i_ready stays high; the result comes out of the sum/round/saturate register
// stages: input register, multiplier register (18 products), sum/round/saturate register
// each stage holds its item while the next cannot take one, so empty stages still take items
// synchronous active-low reset empties the pipeline and loads the identity transform
module aabb_affine_transform (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  aat_pkg::t_box_in           i_box,
    output logic                       o_valid,
    input  logic                       i_ready,
    output aat_pkg::t_box_out          o_box,
    input  logic                       i_cfg_we,
    input  logic [aat_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [aat_pkg::REG_W-1:0]  i_cfg_data
);
    import aat_pkg::*;

    logic     r_in_valid;
    t_box_in  r_in_box;
    logic     w_in_adv;
    logic     w_mul_ready;
    logic     w_mul_valid;
    logic     w_sum_ready;
    t_prod    w_prod;
    t_matrix  w_mat;

    aat_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mat       (w_mat)
    );

    assign w_in_adv = !r_in_valid || w_mul_ready;
    assign o_ready  = w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_valid) begin
            r_in_box <= i_box;
        end
    end

    aat_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (w_mul_ready),
        .i_box   (r_in_box),
        .i_mat   (w_mat),
        .o_valid (w_mul_valid),
        .i_ready (w_sum_ready),
        .o_prod  (w_prod)
    );

    aat_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_sum_ready),
        .i_prod  (w_prod),
        .i_mat   (w_mat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_box   (o_box)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_in_valid && !w_mul_valid)
        else $error("pipeline not empty after reset");

    a_reset_identity: assert property (@(posedge i_clk)
        !i_rst_n |=> w_mat.m[0][0] == Q_ONE && w_mat.m[1][1] == Q_ONE
                     && w_mat.m[2][2] == Q_ONE && w_mat.m[0][1] == '0)
        else $error("matrix not identity after reset");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("empty input stage refuses an item");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_mul_valid))
        else $error("result appeared without a product stage item");

endmodule

@@ sv/aat_cfg_regs.sv @@
// transform matrix registers with magnitudes kept alongside for the extent path
// depends on aat_pkg
module aat_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [aat_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [aat_pkg::REG_W-1:0]  i_cfg_data,
    output aat_pkg::t_matrix           o_mat
);
    import aat_pkg::*;

    t_matrix         r_mat;
    t_matrix         n_mat;
    t_matrix         w_rst_mat;
    logic [Q_W-1:0]  w_hi;
    logic [Q_W-1:0]  w_lo;

    assign w_hi = i_cfg_data[REG_W-1:Q_W];
    assign w_lo = i_cfg_data[Q_W-1:0];

    always_comb begin
        w_rst_mat             = '0;
        w_rst_mat.m[0][0]     = Q_ONE;
        w_rst_mat.m[1][1]     = Q_ONE;
        w_rst_mat.m[2][2]     = Q_ONE;
        w_rst_mat.m_abs[0][0] = Q_ONE;
        w_rst_mat.m_abs[1][1] = Q_ONE;
        w_rst_mat.m_abs[2][2] = Q_ONE;
    end

    always_comb begin
        n_mat = r_mat;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW0_COLS01: begin
                    n_mat.m[0][0] = w_hi; n_mat.m_abs[0][0] = abs_q(w_hi);
                    n_mat.m[0][1] = w_lo; n_mat.m_abs[0][1] = abs_q(w_lo);
                end
                REG_ROW0_COLS23: begin
                    n_mat.m[0][2] = w_hi; n_mat.m_abs[0][2] = abs_q(w_hi);
                    n_mat.tr[0]   = w_lo;
                end
                REG_ROW1_COLS01: begin
                    n_mat.m[1][0] = w_hi; n_mat.m_abs[1][0] = abs_q(w_hi);
                    n_mat.m[1][1] = w_lo; n_mat.m_abs[1][1] = abs_q(w_lo);
                end
                REG_ROW1_COLS23: begin
                    n_mat.m[1][2] = w_hi; n_mat.m_abs[1][2] = abs_q(w_hi);
                    n_mat.tr[1]   = w_lo;
                end
                REG_ROW2_COLS01: begin
                    n_mat.m[2][0] = w_hi; n_mat.m_abs[2][0] = abs_q(w_hi);
                    n_mat.m[2][1] = w_lo; n_mat.m_abs[2][1] = abs_q(w_lo);
                end
                REG_ROW2_COLS23: begin
                    n_mat.m[2][2] = w_hi; n_mat.m_abs[2][2] = abs_q(w_hi);
                    n_mat.tr[2]   = w_lo;
                end
                default: begin
                end
            endcase
        end
    end

    // identity transform out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= w_rst_mat;
        end else begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

endmodule

@@ sv/aat_mul_stage.sv @@
// product stage: nine signed center products and nine extent products, registered
// depends on aat_pkg
module aat_mul_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  aat_pkg::t_box_in  i_box,
    input  aat_pkg::t_matrix  i_mat,
    output logic              o_valid,
    input  logic              i_ready,
    output aat_pkg::t_prod    o_prod
);
    import aat_pkg::*;

    logic                    r_valid;
    t_prod                   r_prod;
    t_prod                   n_prod;
    logic                    w_adv;
    logic [DIM-1:0][Q_W-1:0]   w_c;
    logic [DIM-1:0][EXT_W-1:0] w_e;

    assign w_c[0] = i_box.box_center_x;
    assign w_c[1] = i_box.box_center_y;
    assign w_c[2] = i_box.box_center_z;
    assign w_e[0] = i_box.half_extent_x;
    assign w_e[1] = i_box.half_extent_y;
    assign w_e[2] = i_box.half_extent_z;

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int k = 0; k < DIM; k++) begin
                n_prod.cp[r][k] = $signed(i_mat.m[r][k]) * $signed(w_c[k]);
                n_prod.ep[r][k] = i_mat.m_abs[r][k] * w_e[k];
            end
        end
    end

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

@@ sv/aat_sum_stage.sv @@
// reduction stage: row sums, translation, round half up, saturate, result register
// depends on aat_pkg
module aat_sum_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  aat_pkg::t_prod    i_prod,
    input  aat_pkg::t_matrix  i_mat,
    output logic              o_valid,
    input  logic              i_ready,
    output aat_pkg::t_box_out o_box
);
    import aat_pkg::*;

    logic                       r_valid;
    t_box_out                   r_box;
    t_box_out                   n_box;
    logic                       w_adv;
    logic [DIM-1:0][Q_W-1:0]    w_ctr;
    logic [DIM-1:0][EXT_W-1:0]  w_ext;

    always_comb begin
        logic signed [CSUM_W-1:0]        csum;
        logic signed [CSUM_W-FRAC_W-1:0] cq;
        logic [ESUM_W-1:0]               esum;
        logic [ESUM_W-FRAC_W-1:0]        eq;
        for (int r = 0; r < DIM; r++) begin
            csum = $signed(i_prod.cp[r][0]) + $signed(i_prod.cp[r][1])
                 + $signed(i_prod.cp[r][2]) + ($signed(i_mat.tr[r]) <<< FRAC_W)
                 + CSUM_W'(ROUND_HALF);
            cq = csum[CSUM_W-1:FRAC_W];
            if (&cq[CSUM_W-FRAC_W-1:Q_W-1] || ~|cq[CSUM_W-FRAC_W-1:Q_W-1]) begin
                w_ctr[r] = cq[Q_W-1:0];
            end else if (cq[CSUM_W-FRAC_W-1]) begin
                w_ctr[r] = CTR_MIN;
            end else begin
                w_ctr[r] = CTR_MAX;
            end

            esum = ESUM_W'(i_prod.ep[r][0]) + ESUM_W'(i_prod.ep[r][1])
                 + ESUM_W'(i_prod.ep[r][2]) + ESUM_W'(ROUND_HALF);
            eq = esum[ESUM_W-1:FRAC_W];
            w_ext[r] = (|eq[ESUM_W-FRAC_W-1:EXT_W]) ? EXT_MAX : eq[EXT_W-1:0];
        end
    end

    always_comb begin
        n_box.new_center_x = w_ctr[0];
        n_box.new_center_y = w_ctr[1];
        n_box.new_center_z = w_ctr[2];
        n_box.new_extent_x = w_ext[0];
        n_box.new_extent_y = w_ext[1];
        n_box.new_extent_z = w_ext[2];
    end

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_box <= n_box;
        end
    end

    assign o_valid = r_valid;
    assign o_box   = r_box;

endmodule
